[hw/rtl/gdbt_pkg.sv]
package gdbt_pkg;

    localparam int MaxVerticesDefault = 32;
    localparam int ResultLimit        = 32;

    localparam logic [1:0] OpAddEdge = 2'd0;
    localparam logic [1:0] OpDfs     = 2'd1;
    localparam logic [1:0] OpBfs     = 2'd2;

    localparam logic [2:0] StVisit = 3'd0;
    localparam logic [2:0] StAdded = 3'd1;
    localparam logic [2:0] StDup   = 3'd2;
    localparam logic [2:0] StFull  = 3'd3;
    localparam logic [2:0] StEmpty = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] from_vertex;
        logic [7:0] to_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] vertex_name;
        logic       last;
    } t_out_beat;

endpackage

[hw/rtl/gdbt_if.sv]
interface gdbt_in_if
    import gdbt_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdbt_out_if
    import gdbt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/gdbt_ram.sv]
module gdbt_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/gdbt_datapath.sv]
// Scan-based datapath. Vertex names and the worklist are RAMs; adjacency rows
// are flops (one row per vertex, read at one computed address per cycle).
module gdbt_datapath
    import gdbt_pkg::*;
#(
    parameter int MaxVertices = MaxVerticesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MaxVertices)-1:0] i_scan_idx,
    input  logic                           i_name_we,
    input  logic [$clog2(MaxVertices)-1:0] i_name_waddr,
    input  logic [7:0]                     i_name_wdata,
    output logic [7:0]                     o_name_rdata,
    input  logic [$clog2(MaxVertices)-1:0] i_row_idx,
    output logic [MaxVertices-1:0]         o_row,
    input  logic                           i_row_clr,
    input  logic                           i_row_set,
    input  logic [$clog2(MaxVertices)-1:0] i_row_bit,
    input  logic                           i_wl_we,
    input  logic [$clog2(MaxVertices)-1:0] i_wl_waddr,
    input  logic [$clog2(MaxVertices)-1:0] i_wl_wdata,
    input  logic [$clog2(MaxVertices)-1:0] i_wl_raddr,
    output logic [$clog2(MaxVertices)-1:0] o_wl_rdata
);
    localparam int IW = $clog2(MaxVertices);

    logic [MaxVertices-1:0] r_adj [MaxVertices];

    gdbt_ram #(.Width(8), .Depth(MaxVertices)) u_names (
        .i_clk  (i_clk),
        .i_we   (i_name_we),
        .i_waddr(i_name_waddr),
        .i_wdata(i_name_wdata),
        .i_raddr(i_scan_idx),
        .o_rdata(o_name_rdata)
    );

    gdbt_ram #(.Width(IW), .Depth(MaxVertices)) u_wl (
        .i_clk  (i_clk),
        .i_we   (i_wl_we),
        .i_waddr(i_wl_waddr),
        .i_wdata(i_wl_wdata),
        .i_raddr(i_wl_raddr),
        .o_rdata(o_wl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MaxVertices; k++) begin
                r_adj[k] <= '0;
            end
        end else if (i_row_clr) begin
            r_adj[i_row_idx] <= '0;
        end else if (i_row_set) begin
            r_adj[i_row_idx][i_row_bit] <= 1'b1;
        end
    end

    assign o_row = r_adj[i_row_idx];
endmodule

[hw/rtl/gdbt_ctrl.sv]
// Sequencer. Every search over the vertex table is a linear scan, one vertex a
// cycle, with the name RAM read registered, its data used in the cycle after the address.
module gdbt_ctrl
    import gdbt_pkg::*;
#(
    parameter int MaxVertices = MaxVerticesDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gdbt_in_if.sink                  i_in,
    gdbt_out_if.source               o_out,
    output logic [$clog2(MaxVertices)-1:0] o_scan_idx,
    output logic                     o_name_we,
    output logic [$clog2(MaxVertices)-1:0] o_name_waddr,
    output logic [7:0]               o_name_wdata,
    input  logic [7:0]               i_name_rdata,
    output logic [$clog2(MaxVertices)-1:0] o_row_idx,
    input  logic [MaxVertices-1:0]   i_row,
    output logic                     o_row_clr,
    output logic                     o_row_set,
    output logic [$clog2(MaxVertices)-1:0] o_row_bit,
    output logic                     o_wl_we,
    output logic [$clog2(MaxVertices)-1:0] o_wl_waddr,
    output logic [$clog2(MaxVertices)-1:0] o_wl_wdata,
    output logic [$clog2(MaxVertices)-1:0] o_wl_raddr,
    input  logic [$clog2(MaxVertices)-1:0] i_wl_rdata
);
    localparam int IW = $clog2(MaxVertices);
    localparam int CW = $clog2(MaxVertices + 1);
    localparam int RW = $clog2(ResultLimit + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_ADD, S_START, S_POP, S_POPW, S_SCAN, S_EMIT, S_OUT
    } t_state;

    t_state          r_state;
    logic [1:0]      r_op;
    logic [7:0]      r_from, r_to;
    logic [CW-1:0]   r_total;
    logic [CW-1:0]   r_cnt;       // scan position (address issued)
    logic            r_pipe;      // read data valid for r_cnt-1
    logic            r_ff, r_tf;
    logic [IW-1:0]   r_fi, r_ti;
    logic            r_have;      // best candidate found
    logic [IW-1:0]   r_best;
    logic [7:0]      r_best_name;
    logic            r_have_floor;
    logic [7:0]      r_floor;
    logic [MaxVertices-1:0] r_vis, r_pend, r_set;
    logic [IW-1:0]   r_head;
    logic [CW-1:0]   r_fill;
    logic [IW-1:0]   r_v;
    logic [RW-1:0]   r_nres;
    logic            r_ovalid;
    t_out_beat       r_odata;
    logic            r_hold;      // visit beat parked in r_odata, not yet shown

    logic [IW-1:0]   w_prev;
    logic [IW-1:0]   w_tail;
    logic            w_cand;

    assign w_prev = IW'(r_cnt - CW'(1));
    assign w_tail = IW'(r_head + IW'(r_fill - CW'(1)));
    assign w_cand = r_set[w_prev] && (!r_have_floor || i_name_rdata > r_floor)
                    && (!r_have || i_name_rdata < r_best_name);

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.data   = r_odata;
    assign o_scan_idx   = IW'(r_cnt);
    assign o_name_waddr = IW'(r_total);
    assign o_name_wdata = (r_state == S_ADD && r_ff) ? r_from : r_to;
    assign o_name_we    = (r_state == S_ADD) && (r_ff || r_tf) && !r_ovalid;
    assign o_row_idx    = (r_state == S_ADD) ?
                          ((r_ff || r_tf) ? IW'(r_total) : r_fi) : r_v;
    assign o_row_clr    = o_name_we;
    assign o_row_set    = (r_state == S_ADD) && !r_ff && !r_tf && !r_ovalid
                          && !i_row[r_ti];
    assign o_row_bit    = r_ti;
    assign o_wl_raddr   = (r_op == OpDfs) ? w_tail : r_head;
    assign o_wl_we      = ((r_state == S_START) ||
                           (r_state == S_SCAN && !r_pipe && r_have &&
                            !r_vis[r_best] && !r_pend[r_best]))
                          && r_fill < CW'(MaxVertices);
    assign o_wl_waddr   = IW'(r_head + IW'(r_fill));
    assign o_wl_wdata   = r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_hold   <= 1'b0;
            r_vis    <= '0;
            r_pend   <= '0;
            r_fill   <= '0;
            r_head   <= '0;
        end else begin
            // r_ovalid is only set below while it is low, so this never collides
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op   <= i_in.data.op;
                        r_from <= i_in.data.from_vertex;
                        r_to   <= i_in.data.to_vertex;
                        r_cnt  <= '0;
                        r_pipe <= 1'b0;
                        r_ff   <= 1'b1;
                        r_tf   <= 1'b1;
                        r_have <= 1'b0;
                        r_have_floor <= 1'b0;
                        r_set  <= '1;
                        r_nres <= '0;
                        if (i_in.data.op == OpAddEdge) begin
                            r_state <= S_FIND;
                        end else if (i_in.data.op == OpDfs || i_in.data.op == OpBfs) begin
                            r_vis  <= '0;
                            r_pend <= '0;
                            r_head <= '0;
                            r_fill <= '0;
                            if (r_total == '0) begin
                                r_ovalid <= 1'b1;
                                r_odata  <= '{StEmpty, 8'd0, 1'b1};
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_START;
                            end
                        end
                    end
                end
                S_FIND: begin
                    if (r_pipe) begin
                        if (i_name_rdata == r_from && r_ff) begin
                            r_ff <= 1'b0;
                            r_fi <= w_prev;
                        end
                        if (i_name_rdata == r_to && r_tf) begin
                            r_tf <= 1'b0;
                            r_ti <= w_prev;
                        end
                    end
                    if (r_cnt < r_total) begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_pipe <= 1'b1;
                    end else begin
                        r_pipe <= 1'b0;
                        if (r_pipe) begin
                            // wait for the last read data
                        end else begin
                            if (r_tf && r_from == r_to) begin
                                r_tf <= 1'b0;
                            end
                            if (r_total + CW'(r_ff) +
                                CW'(r_tf && r_from != r_to) > CW'(MaxVertices)) begin
                                r_ovalid <= 1'b1;
                                r_odata  <= '{StFull, 8'd0, 1'b1};
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end
                    end
                end
                S_ADD: begin
                    if (!r_ovalid) begin
                        if (r_ff) begin
                            r_ff    <= 1'b0;
                            r_fi    <= IW'(r_total);
                            if (r_from == r_to) begin
                                r_ti <= IW'(r_total);
                            end
                            r_total <= r_total + CW'(1);
                        end else if (r_tf) begin
                            r_tf    <= 1'b0;
                            r_ti    <= IW'(r_total);
                            r_total <= r_total + CW'(1);
                        end else begin
                            r_ovalid <= 1'b1;
                            r_odata  <= '{(i_row[r_ti] ? StDup : StAdded), 8'd0, 1'b1};
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_START: begin
                    // smallest name over all vertices
                    if (r_pipe && w_cand) begin
                        r_have <= 1'b1;
                        r_best <= w_prev;
                        r_best_name <= i_name_rdata;
                    end
                    if (r_cnt < r_total) begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_pipe <= 1'b1;
                    end else if (r_pipe) begin
                        r_pipe <= 1'b0;
                    end else begin
                        r_pend[r_best] <= 1'b1;
                        r_fill <= CW'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_fill == '0) begin
                        r_head <= '0;
                        r_pend <= '0;
                        // the parked visit is the final beat of the walk
                        if (r_hold) begin
                            r_odata.last <= 1'b1;
                            r_ovalid <= 1'b1;
                            r_hold   <= 1'b0;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    if (r_op != OpDfs) begin
                        r_head <= r_head + IW'(1);
                    end
                    r_pend[i_wl_rdata] <= 1'b0;
                    r_v <= i_wl_rdata;
                    if (r_vis[i_wl_rdata]) begin
                        r_fill <= r_fill - CW'(1);
                        r_state <= S_POP;
                    end else if (r_nres == RW'(ResultLimit)) begin
                        r_fill <= '0;
                        r_state <= S_POP;
                    end else begin
                        r_fill <= r_fill - CW'(1);
                        r_cnt  <= CW'(i_wl_rdata);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // read name of v (addressed by r_cnt), then scan row
                    if (!r_pipe) begin
                        r_pipe <= 1'b1;
                    end else if (r_hold) begin
                        // another visit follows, so the parked one is not last
                        r_ovalid <= 1'b1;
                        r_hold   <= 1'b0;
                    end else if (!r_ovalid) begin
                        r_hold   <= 1'b1;
                        r_odata  <= '{StVisit, i_name_rdata, 1'b0};
                        r_nres   <= r_nres + RW'(1);
                        r_vis[r_v] <= 1'b1;
                        r_set    <= i_row;
                        r_have_floor <= 1'b0;
                        r_have   <= 1'b0;
                        r_cnt    <= '0;
                        r_pipe   <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pipe && w_cand) begin
                        r_have <= 1'b1;
                        r_best <= w_prev;
                        r_best_name <= i_name_rdata;
                    end
                    if (r_cnt < r_total) begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_pipe <= 1'b1;
                    end else if (r_pipe) begin
                        r_pipe <= 1'b0;
                    end else if (!r_have) begin
                        r_state <= S_POP;
                    end else begin
                        if (o_wl_we) begin
                            r_fill <= r_fill + CW'(1);
                            r_pend[r_best] <= 1'b1;
                        end
                        r_have_floor <= 1'b1;
                        r_floor <= r_best_name;
                        r_have  <= 1'b0;
                        r_cnt   <= '0;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/graph_dfs_bfs_traversal.sv]
// Add edge: its beat follows a linear name scan through the name RAM plus up to
// two inserts of new vertices.
// Traversal: a full scan finds the start vertex; then each neighbour in a row is
// found by a full scan, and each vertex visited passes through pop and emit.
// One item at a time; a visited beat is parked until the next visit or the end.
// Synchronous active-low reset empties the graph; the name RAM is not cleared.
module graph_dfs_bfs_traversal
    import gdbt_pkg::*;
#(
    parameter int MaxVertices = MaxVerticesDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdbt_in_if.sink    i_in,
    gdbt_out_if.source o_out
);
    localparam int IW = $clog2(MaxVertices);

    logic [IW-1:0]          w_scan_idx, w_name_waddr, w_row_idx, w_row_bit;
    logic [IW-1:0]          w_wl_waddr, w_wl_wdata, w_wl_raddr, w_wl_rdata;
    logic                   w_name_we, w_row_clr, w_row_set, w_wl_we;
    logic [7:0]             w_name_wdata, w_name_rdata;
    logic [MaxVertices-1:0] w_row;

    gdbt_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .o_out(o_out),
        .o_scan_idx(w_scan_idx), .o_name_we(w_name_we), .o_name_waddr(w_name_waddr),
        .o_name_wdata(w_name_wdata), .i_name_rdata(w_name_rdata),
        .o_row_idx(w_row_idx), .i_row(w_row), .o_row_clr(w_row_clr),
        .o_row_set(w_row_set), .o_row_bit(w_row_bit), .o_wl_we(w_wl_we),
        .o_wl_waddr(w_wl_waddr), .o_wl_wdata(w_wl_wdata), .o_wl_raddr(w_wl_raddr),
        .i_wl_rdata(w_wl_rdata)
    );

    gdbt_datapath #(.MaxVertices(MaxVertices)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_scan_idx(w_scan_idx),
        .i_name_we(w_name_we), .i_name_waddr(w_name_waddr),
        .i_name_wdata(w_name_wdata), .o_name_rdata(w_name_rdata),
        .i_row_idx(w_row_idx), .o_row(w_row), .i_row_clr(w_row_clr),
        .i_row_set(w_row_set), .i_row_bit(w_row_bit), .i_wl_we(w_wl_we),
        .i_wl_waddr(w_wl_waddr), .i_wl_wdata(w_wl_wdata), .i_wl_raddr(w_wl_raddr),
        .o_wl_rdata(w_wl_rdata)
    );

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("output beat dropped");

    property p_status_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.status <= StEmpty;
    endproperty
    a_status_range: assert property (p_status_range) else $error("bad status");

    property p_name_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status != StVisit |-> o_out.data.vertex_name == 8'd0
            && o_out.data.last;
    endproperty
    a_name_zero: assert property (p_name_zero) else $error("nonvisit beat malformed");
endmodule
